FILE: design/mdfe_pkg.sv
// Shared types and codes of the depth-first maze explorer.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package mdfe_pkg;

   // input op codes
   localparam logic [1:0] OP_BEGIN  = 2'd0;
   localparam logic [1:0] OP_ARRIVE = 2'd1;
   localparam logic [1:0] OP_REPLAY = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_FORWARD   = 2'd0;
   localparam logic [1:0] KIND_BACKTRACK = 2'd1;
   localparam logic [1:0] KIND_REPLAY    = 2'd2;
   localparam logic [1:0] KIND_NONE      = 2'd3;

   // exploration phase
   localparam logic [1:0] PHASE_IDLE      = 2'd0;
   localparam logic [1:0] PHASE_FORWARD   = 2'd1;
   localparam logic [1:0] PHASE_BACKTRACK = 2'd2;
   localparam logic [1:0] PHASE_FINISHED  = 2'd3;

   // headings
   localparam logic [1:0] HEAD_NORTH = 2'd0;
   localparam logic [1:0] HEAD_EAST  = 2'd1;
   localparam logic [1:0] HEAD_SOUTH = 2'd2;
   localparam logic [1:0] HEAD_WEST  = 2'd3;

   // turns
   localparam logic [1:0] TURN_NONE  = 2'd0;
   localparam logic [1:0] TURN_CW    = 2'd1;
   localparam logic [1:0] TURN_CCW   = 2'd2;
   localparam logic [1:0] TURN_ABOUT = 2'd3;

   // register indexes
   localparam logic CSR_MAZE_SIDE      = 1'b0;
   localparam logic CSR_WALL_THRESHOLD = 1'b1;

   localparam logic [2:0] TRY_DONE = 3'd4;

   // turn needed for a heading difference (new minus old)
   function automatic logic [1:0] turn_for(input logic [1:0] diff);
      logic [1:0] tn;
      unique case (diff)
         2'd0: tn = TURN_NONE;
         2'd1: tn = TURN_CW;
         2'd2: tn = TURN_ABOUT;
         default: tn = TURN_CCW;
      endcase
      return tn;
   endfunction

   // try order east, north, west, south
   function automatic logic [1:0] try_side(input logic [1:0] t);
      logic [1:0] s;
      unique case (t)
         2'd0: s = HEAD_EAST;
         2'd1: s = HEAD_NORTH;
         2'd2: s = HEAD_WEST;
         default: s = HEAD_SOUTH;
      endcase
      return s;
   endfunction

   typedef struct packed {
      logic load;
      logic clear;
      logic arrive_push;
      logic arrive_back;
      logic decide;
      logic replay;
      logic nomove;
   } mdfe_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] phase;
      logic       revisit;
      logic       backtrack_ready;
      logic       replay_ready;
      logic       out_free;
   } mdfe_status_type;

endpackage

`default_nettype wire

FILE: design/maze_depth_first_explorer_top.sv
// Top level of the depth-first maze explorer: stream ports, register port,
// controller and datapath. Uses mdfe_pkg, mdfe_ctrl and mdfe_dpath.
//
// Usage: send op on req_tuser (0 begin at start cell, 1 arrived, 2 next replay
// move) with the front/left/right range readings on req_tdata. Every accepted
// item yields exactly one result on rsp: move kind on rsp_tuser, heading to
// drive, turn and goal flag on rsp_tdata, and rsp_tlast on the final replay move.
// One item is worked at a time. A begin or forward arrival steps from accept through
// dispatch, map and stack write, fetch and decide; a backtrack arrival or a replay
// request skips the map and stack write, and an ignored item or an arrival at an
// already visited cell gives its result straight after dispatch. The result appears
// in the output register the cycle after the decision. The map, stack and route
// memories have registered reads, which sets the fetch cycle.
// Reset clears the run state (no cell visited, empty stack and route, facing
// north in the bottom row) and loads maze_side 5, wall_threshold 6. When the
// receiver stalls, the result holds; the next item is still accepted and is
// held in its decision step until the output register frees.
`default_nettype none

module maze_depth_first_explorer_top
   import mdfe_pkg::*;
#(
   parameter int GRID_SIDE   = 7,
   parameter int ROUTE_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // range_front[9:0], range_left[19:10], range_right[29:20]
   input  wire logic [1:0]  req_tuser,   // op[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // move_heading[1:0], turn[3:2], goal_found[4]
   output logic [1:0]       rsp_tuser,   // move_kind[1:0]
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [2:0]      maze_side_ff, maze_side_in;
   logic [9:0]      wall_thr_ff, wall_thr_in;
   logic            csr_write;
   mdfe_cmd_type    cmd;
   mdfe_status_type status;
   logic [1:0]      kind, head, turn;
   logic            goal, last;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      maze_side_in = maze_side_ff;
      wall_thr_in  = wall_thr_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_MAZE_SIDE: maze_side_in = csr_pwdata[2:0];
            default:       wall_thr_in  = csr_pwdata[9:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         maze_side_ff <= 3'd5;
         wall_thr_ff  <= 10'd6;
      end else begin
         maze_side_ff <= maze_side_in;
         wall_thr_ff  <= wall_thr_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_MAZE_SIDE: csr_prdata = {29'd0, maze_side_ff};
         default:       csr_prdata = {22'd0, wall_thr_ff};
      endcase
   end

   mdfe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mdfe_dpath #(.GRID_SIDE(GRID_SIDE), .ROUTE_DEPTH(ROUTE_DEPTH)) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_tuser),
      .req_range_front  (req_tdata[9:0]),
      .req_range_left   (req_tdata[19:10]),
      .req_range_right  (req_tdata[29:20]),
      .maze_side        (maze_side_ff),
      .wall_threshold   (wall_thr_ff),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_move_kind    (kind),
      .rsp_move_heading (head),
      .rsp_turn         (turn),
      .rsp_goal_found   (goal),
      .rsp_last_move    (last)
   );

   assign rsp_tdata = {3'b000, goal, turn, head};
   assign rsp_tuser = kind;
   assign rsp_tlast = last;

endmodule

`default_nettype wire

FILE: design/mdfe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mdfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AddrWidth = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AddrWidth-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [AddrWidth-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/mdfe_ctrl.sv
// Sequencer of the maze explorer: steps each item through dispatch and then, as the op and
// phase need, map update, memory fetch, decision or replay. Uses mdfe_pkg; drives mdfe_dpath by commands.
`default_nettype none

module mdfe_ctrl
   import mdfe_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire mdfe_status_type status,
   output mdfe_cmd_type         cmd
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_DISPATCH = 8'b0000_0010,
      ST_ARRIVE   = 8'b0000_0100,
      ST_FETCH    = 8'b0000_1000,
      ST_DECIDE   = 8'b0001_0000,
      ST_RFETCH   = 8'b0010_0000,
      ST_REPLAY   = 8'b0100_0000,
      ST_NOMOVE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.op)
               OP_BEGIN: begin
                  cmd.clear = 1'b1;
                  state_in  = ST_ARRIVE;
               end
               OP_ARRIVE: begin
                  priority if (status.phase == PHASE_FORWARD) begin
                     state_in = ST_ARRIVE;
                  end else if (status.backtrack_ready) begin
                     state_in = ST_FETCH;
                  end else begin
                     state_in = ST_NOMOVE;
                  end
               end
               OP_REPLAY: begin
                  state_in = status.replay_ready ? ST_RFETCH : ST_NOMOVE;
               end
               default: begin
                  state_in = ST_NOMOVE;
               end
            endcase
         end
         ST_ARRIVE: begin
            if (!status.revisit) begin
               cmd.arrive_push = 1'b1;
               state_in        = ST_FETCH;
            end else if (status.out_free) begin
               cmd.arrive_back = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_FETCH: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.out_free) begin
               cmd.decide = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_RFETCH: begin
            state_in = ST_REPLAY;
         end
         ST_REPLAY: begin
            if (status.out_free) begin
               cmd.replay = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_NOMOVE: begin
            if (status.out_free) begin
               cmd.nomove = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

FILE: design/mdfe_dpath.sv
// Datapath of the maze explorer: position, heading, visit flags, map, cell stack,
// route memory and the result register. Uses mdfe_pkg and mdfe_ram.
`default_nettype none

module mdfe_dpath
   import mdfe_pkg::*;
#(
   parameter int GRID_SIDE   = 7,
   parameter int ROUTE_DEPTH = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire mdfe_cmd_type    cmd,
   output mdfe_status_type      status,
   input  wire logic [1:0]      req_op,
   input  wire logic [9:0]      req_range_front,
   input  wire logic [9:0]      req_range_left,
   input  wire logic [9:0]      req_range_right,
   input  wire logic [2:0]      maze_side,
   input  wire logic [9:0]      wall_threshold,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic [1:0]           rsp_move_kind,
   output logic [1:0]           rsp_move_heading,
   output logic [1:0]           rsp_turn,
   output logic                 rsp_goal_found,
   output logic                 rsp_last_move
);

   localparam int CellCount = GRID_SIDE * GRID_SIDE;
   localparam int CW        = $clog2(CellCount);
   localparam int RW        = $clog2(GRID_SIDE);
   localparam int SDW       = $clog2(CellCount + 1);
   localparam int RDW       = $clog2(ROUTE_DEPTH + 1);
   localparam int RAW       = $clog2(ROUTE_DEPTH);
   localparam logic [RW-1:0] LastRow = RW'(GRID_SIDE - 1);

   // latched item
   logic [1:0]  op_ff, op_in;
   logic [9:0]  front_ff, front_in, left_ff, left_in, right_ff, right_in;

   // exploration state
   logic [1:0]           phase_ff, phase_in;
   logic [1:0]           heading_ff, heading_in;
   logic [RW-1:0]        row_ff, row_in, col_ff, col_in;
   logic [SDW-1:0]       sd_ff, sd_in;
   logic [RDW-1:0]       rl_ff, rl_in;
   logic [RDW-1:0]       replay_ff, replay_in;
   logic                 goal_ff, goal_in;
   logic [CellCount-1:0] visited_ff, visited_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [1:0] out_kind_ff, out_kind_in, out_head_ff, out_head_in, out_turn_ff, out_turn_in;
   logic       out_goal_ff, out_goal_in, out_last_ff, out_last_in;

   // memory ports
   logic           open_we, stk_we, route_we;
   logic [3:0]     open_wdata, open_rdata;
   logic [4:0]     stk_wdata, stk_rdata;
   logic [1:0]     route_wdata, route_rdata;
   logic [CW-1:0]  cell_idx, stk_top, stk_waddr;
   logic [RAW-1:0] route_waddr;

   // derived
   logic [2:0]    start_sel;
   logic [RW-1:0] start_col, goal_rc;
   logic          at_start, at_goal, out_free;
   logic [3:0]    in_grid, cand, arrive_bits;
   logic [1:0]    came, t_sel, side_sel, drv_hd;
   logic [2:0]    t0;
   logic          found, drive_en, emit_en, route_dec;
   logic [1:0]    emit_kind, emit_head, emit_turn;
   logic          emit_last;

   assign cell_idx  = CW'(row_ff * GRID_SIDE + col_ff);
   assign stk_top   = CW'(sd_ff - SDW'(1));
   assign out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      start_sel = (maze_side == 3'd5 || maze_side == 3'd6) ? 3'd5 : 3'd6;
      if (32'(start_sel) > GRID_SIDE - 1) begin
         start_col = LastRow;
      end else begin
         start_col = RW'(start_sel);
      end
   end

   assign goal_rc  = (maze_side == 3'd5) ? RW'(1) : RW'(0);
   assign at_start = (row_ff == LastRow) && (col_ff == start_col);
   assign at_goal  = (row_ff == goal_rc) && (col_ff == goal_rc);

   assign in_grid[HEAD_NORTH] = (row_ff != '0);
   assign in_grid[HEAD_EAST]  = (col_ff != LastRow);
   assign in_grid[HEAD_SOUTH] = (row_ff != LastRow);
   assign in_grid[HEAD_WEST]  = (col_ff != '0);

   // open sides seen on a fresh cell; the rear is open except at the start cell
   always_comb begin
      arrive_bits = '0;
      if (front_ff > wall_threshold) arrive_bits[heading_ff] = 1'b1;
      if (left_ff > wall_threshold)  arrive_bits[heading_ff + 2'd3] = 1'b1;
      if (right_ff > wall_threshold) arrive_bits[heading_ff + 2'd1] = 1'b1;
      if (!at_start)                 arrive_bits[heading_ff + 2'd2] = 1'b1;
   end

   // pick the first untried open side that is not straight back
   assign came = stk_rdata[4:3];
   assign t0   = stk_rdata[2:0];

   always_comb begin
      for (int t = 0; t < 4; t++) begin
         cand[t] = (3'(t) >= t0) && open_rdata[try_side(2'(t))]
                   && (try_side(2'(t)) != came + 2'd2) && in_grid[try_side(2'(t))];
      end
      t_sel = 2'd0;
      for (int t = 3; t >= 0; t--) begin
         if (cand[t]) t_sel = 2'(t);
      end
      found    = |cand;
      side_sel = try_side(t_sel);
   end

   always_comb begin
      op_in      = op_ff;
      front_in   = front_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      phase_in   = phase_ff;
      heading_in = heading_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      sd_in      = sd_ff;
      rl_in      = rl_ff;
      replay_in  = replay_ff;
      goal_in    = goal_ff;
      visited_in = visited_ff;

      open_we     = 1'b0;
      open_wdata  = arrive_bits;
      stk_we      = 1'b0;
      stk_waddr   = stk_top;
      stk_wdata   = {came, TRY_DONE};
      route_we    = 1'b0;
      route_waddr = RAW'(rl_ff);
      route_wdata = side_sel;

      drive_en  = 1'b0;
      drv_hd    = heading_ff + 2'd2;
      route_dec = 1'b0;
      emit_en   = 1'b0;
      emit_kind = KIND_NONE;
      emit_head = heading_ff;
      emit_turn = TURN_NONE;
      emit_last = 1'b0;

      if (cmd.load) begin
         op_in    = req_op;
         front_in = req_range_front;
         left_in  = req_range_left;
         right_in = req_range_right;
      end

      if (cmd.clear) begin
         visited_in = '0;
         sd_in      = '0;
         rl_in      = '0;
         goal_in    = 1'b0;
         heading_in = HEAD_NORTH;
         row_in     = LastRow;
         col_in     = start_col;
         replay_in  = '0;
         phase_in   = PHASE_IDLE;
      end

      if (cmd.arrive_push) begin
         visited_in[cell_idx] = 1'b1;
         if (at_goal) goal_in = 1'b1;
         open_we   = 1'b1;
         stk_we    = 1'b1;
         stk_waddr = CW'(sd_ff);
         stk_wdata = {heading_ff, 3'd0};
         sd_in     = sd_ff + SDW'(1);
      end

      if (cmd.arrive_back) begin
         route_dec = 1'b1;
         phase_in  = PHASE_BACKTRACK;
         drive_en  = 1'b1;
         emit_kind = KIND_BACKTRACK;
      end

      if (cmd.decide) begin
         stk_we = 1'b1;
         if (found) begin
            stk_wdata = {came, 3'(t_sel) + 3'd1};
            if (!goal_ff && rl_ff < RDW'(ROUTE_DEPTH)) begin
               route_we = 1'b1;
               rl_in    = rl_ff + RDW'(1);
            end
            phase_in  = PHASE_FORWARD;
            drive_en  = 1'b1;
            drv_hd    = side_sel;
            emit_kind = KIND_FORWARD;
         end else if (sd_ff <= SDW'(1)) begin
            phase_in  = PHASE_FINISHED;
            replay_in = '0;
            emit_en   = 1'b1;
         end else begin
            sd_in     = sd_ff - SDW'(1);
            route_dec = 1'b1;
            phase_in  = PHASE_BACKTRACK;
            drive_en  = 1'b1;
            drv_hd    = came + 2'd2;
            emit_kind = KIND_BACKTRACK;
         end
      end

      if (route_dec && !goal_ff && rl_ff != '0) begin
         rl_in = rl_ff - RDW'(1);
      end

      if (drive_en) begin
         heading_in = drv_hd;
         emit_en    = 1'b1;
         emit_head  = drv_hd;
         emit_turn  = turn_for(drv_hd - heading_ff);
         unique case (drv_hd)
            HEAD_NORTH: if (in_grid[HEAD_NORTH]) row_in = row_ff - RW'(1);
            HEAD_EAST:  if (in_grid[HEAD_EAST])  col_in = col_ff + RW'(1);
            HEAD_SOUTH: if (in_grid[HEAD_SOUTH]) row_in = row_ff + RW'(1);
            default:    if (in_grid[HEAD_WEST])  col_in = col_ff - RW'(1);
         endcase
      end

      if (cmd.replay) begin
         heading_in = route_rdata;
         replay_in  = replay_ff + RDW'(1);
         emit_en    = 1'b1;
         emit_kind  = KIND_REPLAY;
         emit_head  = route_rdata;
         emit_turn  = turn_for(route_rdata - heading_ff);
         emit_last  = (replay_ff + RDW'(1) == rl_ff);
      end

      if (cmd.nomove) begin
         emit_en = 1'b1;
      end

      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_head_in  = out_head_ff;
      out_turn_in  = out_turn_ff;
      out_goal_in  = out_goal_ff;
      out_last_in  = out_last_ff;
      if (emit_en) begin
         out_valid_in = 1'b1;
         out_kind_in  = emit_kind;
         out_head_in  = emit_head;
         out_turn_in  = emit_turn;
         out_goal_in  = goal_in;
         out_last_in  = emit_last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         heading_ff   <= HEAD_NORTH;
         row_ff       <= LastRow;
         col_ff       <= '0;
         sd_ff        <= '0;
         rl_ff        <= '0;
         replay_ff    <= '0;
         goal_ff      <= 1'b0;
         visited_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         heading_ff   <= heading_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         sd_ff        <= sd_in;
         rl_ff        <= rl_in;
         replay_ff    <= replay_in;
         goal_ff      <= goal_in;
         visited_ff   <= visited_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      front_ff    <= front_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      out_kind_ff <= out_kind_in;
      out_head_ff <= out_head_in;
      out_turn_ff <= out_turn_in;
      out_goal_ff <= out_goal_in;
      out_last_ff <= out_last_in;
   end

   mdfe_ram #(.WIDTH(4), .DEPTH(CellCount)) u_open_ram (
      .clock   (clock),
      .wr_en   (open_we),
      .wr_addr (cell_idx),
      .wr_data (open_wdata),
      .rd_addr (cell_idx),
      .rd_data (open_rdata)
   );

   mdfe_ram #(.WIDTH(5), .DEPTH(CellCount)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_top),
      .rd_data (stk_rdata)
   );

   mdfe_ram #(.WIDTH(2), .DEPTH(ROUTE_DEPTH)) u_route_ram (
      .clock   (clock),
      .wr_en   (route_we),
      .wr_addr (route_waddr),
      .wr_data (route_wdata),
      .rd_addr (RAW'(replay_ff)),
      .rd_data (route_rdata)
   );

   assign status.op              = op_ff;
   assign status.phase           = phase_ff;
   assign status.revisit         = visited_ff[cell_idx] || (sd_ff >= SDW'(CellCount));
   assign status.backtrack_ready = (phase_ff == PHASE_BACKTRACK) && (sd_ff != '0);
   assign status.replay_ready    = (phase_ff == PHASE_FINISHED) && (replay_ff < rl_ff)
                                   && (replay_ff < RDW'(ROUTE_DEPTH));
   assign status.out_free        = out_free;

   assign rsp_valid        = out_valid_ff;
   assign rsp_move_kind    = out_kind_ff;
   assign rsp_move_heading = out_head_ff;
   assign rsp_turn         = out_turn_ff;
   assign rsp_goal_found   = out_goal_ff;
   assign rsp_last_move    = out_last_ff;

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sd_ff <= SDW'(CellCount))
      else $error("cell stack overflow");

   a_route_bound: assert property (@(posedge clock) disable iff (reset)
      rl_ff <= RDW'(ROUTE_DEPTH))
      else $error("route length overflow");

   a_replay_bound: assert property (@(posedge clock) disable iff (reset)
      replay_ff <= rl_ff)
      else $error("replay index beyond route");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !emit_en)
      else $error("result emitted over a pending one");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking bench for the depth-first maze explorer: directed table, then random
// exploration runs, replays and noise, checked against an in-bench explorer model.
// Depends on mdfe_pkg and maze_depth_first_explorer_top.
`default_nettype none

module tb_top;
   import mdfe_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIDE = 7;
   localparam int CELLS = SIDE * SIDE;
   localparam int RDEPTH = 64;
   localparam int LIMIT = 400000;
   localparam logic [2:0] ADDR_SIDE = {CSR_MAZE_SIDE, 2'b00};
   localparam logic [2:0] ADDR_THR = {CSR_WALL_THRESHOLD, 2'b00};
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   always #2 clock = ~clock;

   maze_depth_first_explorer_top u_dut (.*);

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] hd;
      logic [1:0] tn;
      logic       goal;
      logic       last;
   } move_type;

   // explorer model state
   logic [3:0] map_open [CELLS];
   logic       map_seen [CELLS];
   logic [1:0] stk_came [CELLS];
   logic [2:0] stk_try [CELLS];
   int         stk_n, route_n, replay_i;
   logic [1:0] route [RDEPTH];
   logic       goal_hit;
   logic [1:0] facing, phase;
   int         row, col;
   logic [2:0] cfg_side;
   logic [9:0] cfg_thr;

   move_type pending_moves[$];
   int mismatches = 0, results_seen = 0, items_sent = 0, cycles = 0;
   bit quiet = 0, hold_rsp = 0;

   function automatic logic [1:0] turn_of(logic [1:0] to, logic [1:0] from);
      logic [1:0] d;
      d = to - from;
      case (d)
         2'd0: return TURN_NONE;
         2'd1: return TURN_CW;
         2'd2: return TURN_ABOUT;
         default: return TURN_CCW;
      endcase
   endfunction

   function automatic int home_col();
      return (cfg_side == 5 || cfg_side == 6) ? 5 : 6;
   endfunction

   function automatic bit on_grid(logic [1:0] h);
      case (h)
         HEAD_NORTH: return row > 0;
         HEAD_EAST: return col + 1 < SIDE;
         HEAD_SOUTH: return row + 1 < SIDE;
         default: return col > 0;
      endcase
   endfunction

   function automatic move_type mk(logic [1:0] k, logic [1:0] h, logic [1:0] t, logic l);
      move_type m;
      m.kind = k; m.hd = h; m.tn = t; m.goal = goal_hit; m.last = l;
      return m;
   endfunction

   function automatic move_type drive_to(logic [1:0] k, logic [1:0] h);
      logic [1:0] t;
      t = turn_of(h, facing);
      facing = h;
      if (on_grid(h))
         case (h)
            HEAD_NORTH: row--;
            HEAD_EAST: col++;
            HEAD_SOUTH: row++;
            default: col--;
         endcase
      return mk(k, h, t, 1'b0);
   endfunction

   function automatic move_type retreat(logic [1:0] h);
      if (!goal_hit && route_n > 0) route_n--;
      phase = PHASE_BACKTRACK;
      return drive_to(KIND_BACKTRACK, h);
   endfunction

   function automatic move_type choose_move();
      int top, cell_no;
      logic [1:0] came, s;
      top = stk_n - 1;
      cell_no = row * SIDE + col;
      came = stk_came[top];
      for (int t = stk_try[top]; t < 4; t++) begin
         s = try_side(t[1:0]);
         if (map_open[cell_no][s] && s != came + 2'd2 && on_grid(s)) begin
            stk_try[top] = t + 1;
            if (!goal_hit && route_n < RDEPTH) begin
               route[route_n] = s;
               route_n++;
            end
            phase = PHASE_FORWARD;
            return drive_to(KIND_FORWARD, s);
         end
      end
      stk_try[top] = TRY_DONE;
      if (stk_n <= 1) begin
         phase = PHASE_FINISHED;
         replay_i = 0;
         return mk(KIND_NONE, facing, TURN_NONE, 1'b0);
      end
      stk_n--;
      return retreat(came + 2'd2);
   endfunction

   function automatic move_type enter_cell(logic [9:0] f, logic [9:0] l, logic [9:0] r);
      int cell_no, gl;
      logic [3:0] b;
      cell_no = row * SIDE + col;
      gl = (cfg_side == 5) ? 1 : 0;
      b = '0;
      if (map_seen[cell_no] || stk_n >= CELLS) return retreat(facing + 2'd2);
      map_seen[cell_no] = 1'b1;
      if (row == gl && col == gl) goal_hit = 1'b1;
      if (f > cfg_thr) b[facing] = 1'b1;
      if (l > cfg_thr) b[facing + 2'd3] = 1'b1;
      if (r > cfg_thr) b[facing + 2'd1] = 1'b1;
      if (row != SIDE - 1 || col != home_col()) b[facing + 2'd2] = 1'b1;
      map_open[cell_no] |= b;
      stk_came[stk_n] = facing;
      stk_try[stk_n] = '0;
      stk_n++;
      return choose_move();
   endfunction

   function automatic void wipe_run();
      for (int i = 0; i < CELLS; i++) begin
         map_open[i] = '0; map_seen[i] = 1'b0;
      end
      stk_n = 0; route_n = 0; goal_hit = 0; facing = HEAD_NORTH;
      row = SIDE - 1; replay_i = 0; phase = PHASE_IDLE;
   endfunction

   function automatic move_type predict_move(logic [1:0] op, logic [9:0] f, logic [9:0] l,
                                             logic [9:0] r);
      logic [1:0] h;
      logic [1:0] t;
      if (op == OP_BEGIN) begin
         wipe_run();
         col = home_col();
         return enter_cell(f, l, r);
      end
      if (op == OP_ARRIVE) begin
         if (phase == PHASE_FORWARD) return enter_cell(f, l, r);
         if (phase == PHASE_BACKTRACK && stk_n > 0) return choose_move();
         return mk(KIND_NONE, facing, TURN_NONE, 1'b0);
      end
      if (op == OP_REPLAY && phase == PHASE_FINISHED && replay_i < route_n) begin
         h = route[replay_i];
         t = turn_of(h, facing);
         facing = h;
         replay_i++;
         return mk(KIND_REPLAY, h, t, replay_i == route_n);
      end
      return mk(KIND_NONE, facing, TURN_NONE, 1'b0);
   endfunction

   // result checker and receiver stall
   always @(posedge clock) begin
      move_type got, want;
      cycles <= cycles + 1;
      if (rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser; got.hd = rsp_tdata[1:0]; got.tn = rsp_tdata[3:2];
         got.goal = rsp_tdata[4]; got.last = rsp_tlast;
         results_seen <= results_seen + 1;
         if (pending_moves.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected result %p", got);
         end else begin
            want = pending_moves.pop_front();
            if (got !== want) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("mismatch: expected %p got %p", want, got);
            end
         end
      end
   end

   int stall_left = 0;
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_rsp) rsp_tready <= 1'b0;
      else if (quiet) rsp_tready <= 1'b1;
      else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 9) - 1;
         rsp_tready <= 1'b0;
      end else rsp_tready <= 1'b1;
   end

   initial begin
      wait (cycles >= LIMIT);
      $display("[maze_depth_first_explorer_top] ERROR");
      $finish;
   end

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1; csr_paddr <= addr; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (addr == ADDR_SIDE) cfg_side = value[2:0];
      else cfg_thr = value[9:0];
   endtask

   task automatic drain();
      while (pending_moves.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // hand one item to the block; req_tvalid stays high across back-to-back items
   task automatic send_item(logic [1:0] op, logic [9:0] f, logic [9:0] l, logic [9:0] r);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {2'b00, r, l, f};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_moves.push_back(predict_move(op, f, l, r));
      items_sent++;
      @(negedge clock);
   endtask

   function automatic logic [9:0] reading();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return 10'h3ff;
         default: return $urandom_range(0, 1023);
      endcase
   endfunction

   // one run from begin to finish (at most 400 further items), then a full replay
   task automatic explore_run(bit with_noise);
      move_type last_pred;
      int n;
      send_item(OP_BEGIN, reading(), reading(), reading());
      n = 0;
      while (phase != PHASE_FINISHED && n < 400) begin
         if (with_noise && $urandom_range(0, 19) == 0)
            send_item($urandom_range(0, 3) == 0 ? OP_UNUSED : OP_REPLAY, reading(), reading(),
                      reading());
         else send_item(OP_ARRIVE, reading(), reading(), reading());
         n++;
      end
      for (int i = 0; i <= route_n; i++)
         send_item(OP_REPLAY, reading(), reading(), reading());
   endtask

   typedef struct {
      logic [1:0] op;
      logic [9:0] f, l, r;
      bit         typed;
      move_type   want;
   } plan_row_type;

   initial begin
      plan_row_type plan[$];
      plan_row_type e;
      move_type p;
      wipe_run();
      col = 0; cfg_side = 5; cfg_thr = 6;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed: idle-state items give no move facing north, then real walks
      e = '{OP_ARRIVE, 10'd0, 10'd0, 10'd0, 1, '{KIND_NONE, HEAD_NORTH, TURN_NONE, 0, 0}};
      plan.push_back(e);
      e.op = OP_REPLAY; plan.push_back(e);
      e.op = OP_UNUSED; e.f = 10'h3ff; e.l = 10'h3ff; e.r = 10'h3ff; plan.push_back(e);
      // begin with all walls closed: start cell is a dead end at once
      e = '{OP_BEGIN, 10'd6, 10'd6, 10'd6, 1, '{KIND_NONE, HEAD_NORTH, TURN_NONE, 0, 0}};
      plan.push_back(e);
      e.op = OP_REPLAY; plan.push_back(e);
      e.op = OP_ARRIVE; plan.push_back(e);
      // begin with only front open: forward north, no turn
      e = '{OP_BEGIN, 10'd7, 10'd0, 10'd0, 1, '{KIND_FORWARD, HEAD_NORTH, TURN_NONE, 0, 0}};
      plan.push_back(e);
      e = '{OP_ARRIVE, 10'd0, 10'd0, 10'd0, 0, '0}; plan.push_back(e);
      e = '{OP_ARRIVE, 10'h3ff, 10'h3ff, 10'h3ff, 0, '0}; plan.push_back(e);
      // begin with right open: east is tried first, clockwise
      e = '{OP_BEGIN, 10'd0, 10'd0, 10'h3ff, 1, '{KIND_FORWARD, HEAD_EAST, TURN_CW, 0, 0}};
      plan.push_back(e);
      for (int i = 0; i < 12; i++) begin
         e = '{OP_ARRIVE, 10'h3ff, 10'h3ff, 10'h3ff, 0, '0};
         plan.push_back(e);
      end
      foreach (plan[i]) begin
         p = predict_move(plan[i].op, plan[i].f, plan[i].l, plan[i].r);
         if (plan[i].typed && p != plan[i].want) begin
            mismatches++;
            $display("directed row %0d: table %p model %p", i, plan[i].want, p);
         end
         // undo by re-running through send_item would predict twice; push directly
         req_tvalid <= 1'b1;
         req_tuser <= plan[i].op;
         req_tdata <= {2'b00, plan[i].r, plan[i].l, plan[i].f};
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         pending_moves.push_back(plan[i].typed ? plan[i].want : p);
         items_sent++;
         @(negedge clock);
      end
      req_tvalid <= 1'b0;
      drain();

      // receiver holds off while runs keep coming, so the input backs up
      fork
         begin
            hold_rsp = 1;
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end
         repeat (3) explore_run(0);
      join
      req_tvalid <= 1'b0;
      drain();

      // settings sweep, extremes included
      for (int s = 0; s < 8; s++) begin
         csr_write(ADDR_SIDE, s);
         case (s % 4)
            0: csr_write(ADDR_THR, 32'd0);
            1: csr_write(ADDR_THR, 32'd1023);
            2: csr_write(ADDR_THR, 32'd6);
            default: csr_write(ADDR_THR, $urandom_range(1, 1022));
         endcase
         while (items_sent < 200 + s * 90) explore_run(1);
         // sender pauses until every result is in
         req_tvalid <= 1'b0;
         drain();
      end
      csr_write(ADDR_SIDE, 32'd5);
      csr_write(ADDR_THR, 32'd500);
      quiet = 1;
      repeat (2) explore_run(1);
      req_tvalid <= 1'b0;
      drain();

      $display("covered %0d items and %0d results over all maze sizes and thresholds 0..1023,",
               items_sent, results_seen);
      $display("with walk, backtrack, replay, noise and long receiver stalls");
      if (mismatches == 0 && pending_moves.size() == 0)
         $display("[maze_depth_first_explorer_top] OK");
      else
         $display("[maze_depth_first_explorer_top] ERROR");
      $finish;
   end
endmodule

`default_nettype wire

FILE: filelist.f
design/mdfe_pkg.sv
design/mdfe_ram.sv
design/mdfe_ctrl.sv
design/mdfe_dpath.sv
design/maze_depth_first_explorer_top.sv
sim/tb_top.sv
